// ----- rtl/core/ed3_pkg.sv -----
// Shared constants and types of the 3x3 edge detector.
`timescale 1ns / 1ps
`default_nettype none

package ed3_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int CFG_DATA_W = 13;
  localparam int PIX_W      = 24;
  localparam int CHAN_W     = 8;
  localparam int CHAN_MAX   = 255;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [FW_W-1:0] RESET_WIDTH  = FW_W'(640);
  localparam logic [FH_W-1:0] RESET_HEIGHT = FH_W'(480);

  // Input command codes.
  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // Configuration register indexes.
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    logic valid;
    logic zero;
    logic last;
  } emit_ctrl_t;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              last;
  } result_t;

endpackage

`default_nettype wire

// ----- rtl/core/edge_detect_3x3_unit.sv -----
// Streaming 3x3 Laplacian edge detector on RGB pixels, top level.
// Throughput: one item per cycle while in_stall_o is low; the line store memory is
// read for each accepted item and written for each pixel. A result passes the input,
// window and queue registers; a pixel releases the result of the pixel W+1 positions
// earlier. Reset: counters, window and output queue clear, width 640 and height 480;
// the line store memory is not cleared and the block takes items right after reset.
`timescale 1ns / 1ps
`default_nettype none

module edge_detect_3x3_unit (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire                               command_i,
  input  wire  [ed3_pkg::CHAN_W-1:0]        red_in_i,
  input  wire  [ed3_pkg::CHAN_W-1:0]        green_in_i,
  input  wire  [ed3_pkg::CHAN_W-1:0]        blue_in_i,
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic [ed3_pkg::CHAN_W-1:0]        red_out_o,
  output logic [ed3_pkg::CHAN_W-1:0]        green_out_o,
  output logic [ed3_pkg::CHAN_W-1:0]        blue_out_o,
  output logic                              frame_end_o,
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire                               cfg_index_i,
  input  wire  [ed3_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  // Configuration registers and effective frame size.
  logic [ed3_pkg::FW_W-1:0] frame_width_q;
  logic [ed3_pkg::FH_W-1:0] frame_height_q;
  logic [ed3_pkg::FW_W-1:0] w_eff;
  logic [ed3_pkg::FH_W-1:0] h_eff;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= ed3_pkg::RESET_WIDTH;
      frame_height_q <= ed3_pkg::RESET_HEIGHT;
    end else if (cfg_valid_i && cfg_ready_o) begin
      if (cfg_index_i == ed3_pkg::REG_FRAME_WIDTH) begin
        frame_width_q <= cfg_data_i[ed3_pkg::FW_W-1:0];
      end else begin
        frame_height_q <= cfg_data_i;
      end
    end
  end

  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = ed3_pkg::FW_W'(1);
    end else if (frame_width_q > ed3_pkg::FW_W'(ed3_pkg::MAX_WIDTH)) begin
      w_eff = ed3_pkg::FW_W'(ed3_pkg::MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = ed3_pkg::FH_W'(1);
    end else if (frame_height_q > ed3_pkg::FH_W'(ed3_pkg::MAX_HEIGHT)) begin
      h_eff = ed3_pkg::FH_W'(ed3_pkg::MAX_HEIGHT);
    end else begin
      h_eff = frame_height_q;
    end
  end

  // Input stage: accept, column count, line store read.
  logic                               s1_valid_q;
  logic                               s1_cmd_q;
  ed3_pkg::pixel_t                    s1_px_q;
  logic [ed3_pkg::COL_W-1:0]          s1_col_q;
  logic                               s1_fwd_q;
  ed3_pkg::pixel_t                    s1_fwd_near_q;
  ed3_pkg::pixel_t                    s1_fwd_far_q;
  ed3_pkg::emit_ctrl_t                s2_ctrl_q, s2_ctrl_d;
  logic [ed3_pkg::FIFO_CNT_W-1:0]     fifo_count;
  logic [ed3_pkg::FIFO_CNT_W-1:0]     occupancy;
  logic                               in_accept;
  logic [ed3_pkg::COL_W-1:0]          in_col_q, in_col_d;

  // Credit check: everything in flight must fit in the output queue.
  assign occupancy  = fifo_count + ed3_pkg::FIFO_CNT_W'(s1_valid_q)
                    + ed3_pkg::FIFO_CNT_W'(s2_ctrl_q.valid);
  assign in_stall_o = (occupancy >= ed3_pkg::FIFO_CNT_W'(ed3_pkg::FIFO_DEPTH));
  assign in_accept  = in_valid_i && !in_stall_o;

  always_comb begin
    in_col_d = in_col_q;
    if (in_accept && command_i == ed3_pkg::CMD_PIXEL) begin
      if ({1'b0, in_col_q} + 1'b1 >= w_eff) begin
        in_col_d = '0;
      end else begin
        in_col_d = in_col_q + 1'b1;
      end
    end
  end

  logic [2*ed3_pkg::PIX_W-1:0] rd_data;
  ed3_pkg::pixel_t             s1_near;
  ed3_pkg::pixel_t             s1_far;
  logic                        s1_pixel;

  assign s1_pixel = s1_valid_q && (s1_cmd_q == ed3_pkg::CMD_PIXEL);
  assign s1_near  = s1_fwd_q ? s1_fwd_near_q : rd_data[ed3_pkg::PIX_W-1:0];
  assign s1_far   = s1_fwd_q ? s1_fwd_far_q  : rd_data[2*ed3_pkg::PIX_W-1:ed3_pkg::PIX_W];

  ed3_line_store u_line_store (
    .clk_i     (clk_i),
    .rd_en_i   (in_accept),
    .rd_addr_i (in_col_q),
    .rd_data_o (rd_data),
    .wr_en_i   (s1_pixel),
    .wr_addr_i (s1_col_q),
    .wr_data_i ({s1_near, s1_px_q})
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      in_col_q   <= in_col_d;
      s1_valid_q <= in_accept;
    end
  end

  // The write of the transaction ahead lands in the same cycle as this read, so
  // a hit on its column takes the data being written instead of the memory.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_cmd_q      <= command_i;
      s1_px_q       <= {red_in_i, green_in_i, blue_in_i};
      s1_col_q      <= in_col_q;
      s1_fwd_q      <= s1_pixel && (s1_col_q == in_col_q);
      s1_fwd_near_q <= s1_px_q;
      s1_fwd_far_q  <= s1_near;
    end
  end

  // Window stage: pending count, result position and emit decision.
  logic [ed3_pkg::FW_W-1:0]  pend_q, pend_d;
  logic [ed3_pkg::COL_W-1:0] out_col_q, out_col_d;
  logic [ed3_pkg::ROW_W-1:0] out_row_q, out_row_d;
  logic                      emit;
  logic                      col_end;
  logic                      row_end;

  assign col_end = ({1'b0, out_col_q} + 1'b1 >= w_eff);
  assign row_end = ({1'b0, out_row_q} + 1'b1 >= h_eff);

  always_comb begin
    pend_d    = pend_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;
    emit      = 1'b0;
    if (s1_valid_q) begin
      if (s1_cmd_q == ed3_pkg::CMD_PIXEL) begin
        emit = (pend_q > w_eff);
        if (!emit) begin
          pend_d = pend_q + 1'b1;
        end
      end else if (pend_q != '0) begin
        emit   = 1'b1;
        pend_d = pend_q - 1'b1;
      end
    end
    if (emit) begin
      if (col_end) begin
        out_col_d = '0;
        out_row_d = row_end ? '0 : out_row_q + 1'b1;
      end else begin
        out_col_d = out_col_q + 1'b1;
      end
    end
    s2_ctrl_d.valid = emit;
    s2_ctrl_d.zero  = !s1_pixel || (out_col_q == '0) || col_end
                    || (out_row_q == '0) || row_end;
    s2_ctrl_d.last  = col_end && row_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
      s2_ctrl_q <= '0;
    end else begin
      pend_q    <= pend_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
      s2_ctrl_q <= s2_ctrl_d;
    end
  end

  // Kernel stage and output queue.
  ed3_pkg::result_t kernel_res;
  ed3_pkg::result_t head;
  logic             pop;

  ed3_window u_window (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .shift_i  (s1_pixel),
    .far_i    (s1_far),
    .near_i   (s1_near),
    .px_i     (s1_px_q),
    .ctrl_i   (s2_ctrl_q),
    .result_o (kernel_res)
  );

  assign pop = out_valid_o && !out_stall_i;

  ed3_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s2_ctrl_q.valid),
    .push_data_i (kernel_res),
    .pop_i       (pop),
    .head_o      (head),
    .not_empty_o (out_valid_o),
    .count_o     (fifo_count)
  );

  assign red_out_o   = head.red;
  assign green_out_o = head.green;
  assign blue_out_o  = head.blue;
  assign frame_end_o = head.last;

endmodule

`default_nettype wire

// ----- rtl/core/ed3_line_store.sv -----
// Two line stores held side by side in one synchronous memory.
`timescale 1ns / 1ps
`default_nettype none

module ed3_line_store (
  input  wire                         clk_i,
  input  wire                         rd_en_i,
  input  wire  [ed3_pkg::COL_W-1:0]   rd_addr_i,
  output logic [2*ed3_pkg::PIX_W-1:0] rd_data_o,
  input  wire                         wr_en_i,
  input  wire  [ed3_pkg::COL_W-1:0]   wr_addr_i,
  input  wire  [2*ed3_pkg::PIX_W-1:0] wr_data_i
);

  // Upper half holds the far row, lower half the near row.
  logic [2*ed3_pkg::PIX_W-1:0] mem_q [0:ed3_pkg::MAX_WIDTH-1];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/ed3_window.sv -----
// 3x3 pixel window and the Laplacian kernel applied to it.
`timescale 1ns / 1ps
`default_nettype none

module ed3_window (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 shift_i,
  input  ed3_pkg::pixel_t     far_i,
  input  ed3_pkg::pixel_t     near_i,
  input  ed3_pkg::pixel_t     px_i,
  input  ed3_pkg::emit_ctrl_t ctrl_i,
  output ed3_pkg::result_t    result_o
);

  ed3_pkg::pixel_t window_q [0:8];
  ed3_pkg::pixel_t window_d [0:8];

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      window_d[k] = window_q[k];
    end
    if (shift_i) begin
      for (int r = 0; r < 3; r++) begin
        window_d[r*3]   = window_q[r*3+1];
        window_d[r*3+1] = window_q[r*3+2];
      end
      window_d[2] = far_i;
      window_d[5] = near_i;
      window_d[8] = px_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 9; k++) begin
        window_q[k] <= '0;
      end
    end else begin
      for (int k = 0; k < 9; k++) begin
        window_q[k] <= window_d[k];
      end
    end
  end

  // Eight times the center minus the eight neighbors, clamped to 0..255.
  logic [ed3_pkg::CHAN_W-1:0] chan_res [0:2];

  always_comb begin
    logic [ed3_pkg::CHAN_W+2:0] nsum;
    logic [ed3_pkg::CHAN_W+4:0] acc;
    for (int ch = 0; ch < 3; ch++) begin
      nsum = '0;
      for (int k = 0; k < 9; k++) begin
        if (k != 4) begin
          nsum = nsum + (ed3_pkg::CHAN_W+3)'(window_q[k][(2-ch)*8 +: 8]);
        end
      end
      acc = {2'b00, window_q[4][(2-ch)*8 +: 8], 3'b000} - {2'b00, nsum};
      if (acc[ed3_pkg::CHAN_W+4]) begin
        chan_res[ch] = '0;
      end else if (acc[ed3_pkg::CHAN_W+3:0] > (ed3_pkg::CHAN_W+4)'(ed3_pkg::CHAN_MAX)) begin
        chan_res[ch] = ed3_pkg::CHAN_W'(ed3_pkg::CHAN_MAX);
      end else begin
        chan_res[ch] = acc[ed3_pkg::CHAN_W-1:0];
      end
    end
  end

  always_comb begin
    result_o.red   = ctrl_i.zero ? '0 : chan_res[0];
    result_o.green = ctrl_i.zero ? '0 : chan_res[1];
    result_o.blue  = ctrl_i.zero ? '0 : chan_res[2];
    result_o.last  = ctrl_i.last;
  end

endmodule

`default_nettype wire

// ----- rtl/core/ed3_out_fifo.sv -----
// Small output queue that decouples the kernel from the result channel.
`timescale 1ns / 1ps
`default_nettype none

module ed3_out_fifo (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              push_i,
  input  ed3_pkg::result_t                 push_data_i,
  input  wire                              pop_i,
  output ed3_pkg::result_t                 head_o,
  output logic                             not_empty_o,
  output logic [ed3_pkg::FIFO_CNT_W-1:0]   count_o
);

  ed3_pkg::result_t                entry_q [0:ed3_pkg::FIFO_DEPTH-1];
  logic [ed3_pkg::FIFO_PTR_W-1:0]  head_q, head_d;
  logic [ed3_pkg::FIFO_PTR_W-1:0]  tail_q, tail_d;
  logic [ed3_pkg::FIFO_CNT_W-1:0]  count_q, count_d;

  always_comb begin
    head_d  = pop_i  ? head_q + 1'b1 : head_q;
    tail_d  = push_i ? tail_q + 1'b1 : tail_q;
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      tail_q  <= tail_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= push_data_i;
    end
  end

  assign head_o      = entry_q[head_q];
  assign not_empty_o = (count_q != '0);
  assign count_o     = count_q;

endmodule

`default_nettype wire
